### hw/rtl/plins_pkg.sv
// Package with the constants, codes and state type of the positional list insert block.
package plins_pkg;

  // Store size and field widths.
  localparam int DEPTH       = 32;
  localparam int TOKEN_WIDTH = 16;
  localparam int POS_W       = 8;
  localparam int LEN_W       = 6;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;

  // Derived widths: slot index, token count and the position compare.
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Request modes carried by an input transaction.
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST   = 2'd0,
    MODE_LAST    = 2'd1,
    MODE_POS     = 2'd2,
    MODE_DISPLAY = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_PAST_END = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_RESP,
    ST_DISP_RD,
    ST_DISP_OUT
  } state_t;

endpackage

### hw/rtl/positional_list_insert_top.sv
// Top level of the positional list insert block: token store, sequencer and result register.
//
//   Channel  Direction  Ports                                            Handshake
//   in       input      in_mode, in_position, in_token                   in_valid / in_ready
//   out      output     out_status, out_token_out, out_list_length,      out_valid / out_ready
//                       out_last
//
// An insert moves every token from the target slot onward back one slot (count - slot tokens),
// each move being one registered read and then one write of the store.
// A display reads and emits the tokens in order; a refused insert or an empty display
// gives a single result.
// Reset clears the token count, the sequencer and the result valid flag; the store itself is never cleared.
// A new transaction is taken only in the idle state; a stalled result holds the sequencer.
module positional_list_insert_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [plins_pkg::MODE_W-1:0]    in_mode,
  input  logic [plins_pkg::POS_W-1:0]     in_position,
  input  logic [plins_pkg::TOKEN_WIDTH-1:0] in_token,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [plins_pkg::STATUS_W-1:0]  out_status,
  output logic [plins_pkg::TOKEN_WIDTH-1:0] out_token_out,
  output logic [plins_pkg::LEN_W-1:0]     out_list_length,
  output logic                            out_last
);
  import plins_pkg::*;

  // Token store.
  logic [TOKEN_WIDTH-1:0] mem [DEPTH];
  logic [TOKEN_WIDTH-1:0] rd_data_r;

  // Sequencer and working registers.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [TOKEN_WIDTH-1:0] tok_r, tok_nxt;
  status_t          stat_r, stat_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [TOKEN_WIDTH-1:0] out_token_r, out_token_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;
  logic                   out_last_r, out_last_nxt;

  // Store port controls.
  logic                   mem_wr_en;
  logic [IDX_W-1:0]       mem_wr_addr;
  logic [TOKEN_WIDTH-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [IDX_W-1:0]       mem_rd_addr;

  // Request decode helpers.
  mode_t            req_mode;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [CMP_W-1:0] cnt_p1;
  logic             is_full;
  logic [IDX_W-1:0] cnt_idx;
  logic             in_fire;
  logic             out_free;
  logic [CNT_W-1:0] ptr_p1;
  logic             disp_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign req_mode  = mode_t'(in_mode);
  assign pos_ext   = CMP_W'(in_position);
  assign pos_m1    = pos_ext - CMP_W'(1);
  assign cnt_p1    = CMP_W'(count_r) + CMP_W'(1);
  assign is_full   = (count_r >= CNT_W'(DEPTH));
  assign cnt_idx   = count_r[IDX_W-1:0];
  assign ptr_p1    = CNT_W'(ptr_r) + CNT_W'(1);
  assign disp_last = (ptr_p1 == count_r);

  // Store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    tok_r        <= tok_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_token_r  <= out_token_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Next state, store controls and result loading.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    tok_nxt        = tok_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_token_nxt  = out_token_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = idx_r;
    mem_wr_data    = tok_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          tok_nxt  = in_token;
          stat_nxt = STAT_OK;
          if (req_mode == MODE_DISPLAY) begin
            // Display walks the list from the front, or reports an empty list.
            ptr_nxt = '0;
            if (count_r == '0) begin
              stat_nxt  = STAT_EMPTY;
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_DISP_RD;
            end
          end else if ((req_mode == MODE_POS) && (in_position == '0)) begin
            stat_nxt  = STAT_INVALID;
            state_nxt = ST_RESP;
          end else if ((req_mode == MODE_POS) && (pos_ext > cnt_p1)) begin
            stat_nxt  = STAT_PAST_END;
            state_nxt = ST_RESP;
          end else if (is_full) begin
            stat_nxt  = STAT_FULL;
            state_nxt = ST_RESP;
          end else begin
            // Target slot; the tail from that slot onward moves back by one.
            case (req_mode)
              MODE_FIRST: idx_nxt = '0;
              MODE_LAST:  idx_nxt = cnt_idx;
              default:    idx_nxt = pos_m1[IDX_W-1:0];
            endcase
            ptr_nxt = cnt_idx;
            if (cnt_idx == idx_nxt) begin
              state_nxt = ST_WRITE;
            end else begin
              state_nxt = ST_SHIFT_RD;
            end
          end
        end
      end

      ST_SHIFT_RD: begin
        // Fetch the entry just ahead of the free slot.
        mem_rd_en   = 1'b1;
        mem_rd_addr = ptr_r - IDX_W'(1);
        state_nxt   = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        // Move it back into the free slot; the free slot moves one step forward.
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r;
        mem_wr_data = rd_data_r;
        ptr_nxt     = ptr_r - IDX_W'(1);
        if (ptr_nxt == idx_r) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_SHIFT_RD;
        end
      end

      ST_WRITE: begin
        // Store the new token and grow the list.
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = tok_r;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = ST_RESP;
      end

      ST_RESP: begin
        // Single result of an insert or of an empty display.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_token_nxt  = '0;
          out_len_nxt    = LEN_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_DISP_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = ptr_r;
        state_nxt   = ST_DISP_OUT;
      end

      ST_DISP_OUT: begin
        // Emit one token; the read data holds until the result slot frees up.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_token_nxt  = rd_data_r;
          out_len_nxt    = LEN_W'(count_r);
          out_last_nxt   = disp_last;
          if (disp_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = ST_DISP_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_token_out   = out_token_r;
  assign out_list_length = out_len_r;
  assign out_last        = out_last_r;

endmodule

### sim/positional_list_insert_top_tb.sv
// Self-checking testbench for the positional list insert block with a token-list predictor.
module positional_list_insert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plins_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 100;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [TOKEN_WIDTH-1:0] tok;
    logic [LEN_W-1:0]       len;
    logic                   last;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [MODE_W-1:0]      in_mode = '0;
  logic [POS_W-1:0]       in_position = '0;
  logic [TOKEN_WIDTH-1:0] in_token = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [TOKEN_WIDTH-1:0] out_token_out;
  logic [LEN_W-1:0]       out_list_length;
  logic                   out_last;

  // Predicted list contents and the results still owed by the block.
  logic [TOKEN_WIDTH-1:0] held_tokens [DEPTH];
  int                     held_count = 0;
  list_result_t           owed_results [$];

  int errors = 0;
  int quiet_cycles = 0;
  int ready_stall_left = 0;
  bit idle_enabled = 1'b1;

  positional_list_insert_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_token        (in_token),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_token_out   (out_token_out),
    .out_list_length (out_list_length),
    .out_last        (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Update the predicted list for one accepted request and queue its results.
  task automatic predict_list_step(input logic [MODE_W-1:0] mode,
                                   input logic [POS_W-1:0] pos,
                                   input logic [TOKEN_WIDTH-1:0] tok);
    list_result_t r;
    int slot;
    int i;
    r.status = STAT_OK;
    r.tok    = '0;
    r.last   = 1'b1;
    slot     = -1;
    if (mode == MODE_DISPLAY) begin
      r.len = LEN_W'(held_count);
      if (held_count == 0) begin
        r.status = STAT_EMPTY;
        owed_results.push_back(r);
      end else begin
        for (i = 0; i < held_count; i++) begin
          r.tok  = held_tokens[i];
          r.last = (i == held_count - 1);
          owed_results.push_back(r);
        end
      end
    end else begin
      // Position checks come before the full check for positional inserts.
      if (mode == MODE_POS) begin
        if (pos == 0) r.status = STAT_INVALID;
        else if (int'(pos) > held_count + 1) r.status = STAT_PAST_END;
        else if (held_count >= DEPTH) r.status = STAT_FULL;
        else slot = int'(pos) - 1;
      end else if (held_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        slot = (mode == MODE_FIRST) ? 0 : held_count;
      end
      if (slot >= 0) begin
        for (i = held_count; i > slot; i--) held_tokens[i] = held_tokens[i-1];
        held_tokens[slot] = tok;
        held_count++;
      end
      r.len = LEN_W'(held_count);
      owed_results.push_back(r);
    end
  endtask

  // Compare one accepted result transaction with the oldest owed result.
  task automatic check_list_result();
    list_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual status=%0d token=%h len=%0d last=%0b",
               $time, out_status, out_token_out, out_list_length, out_last);
      errors++;
    end else begin
      want = owed_results.pop_front();
      if (out_status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, out_status);
        errors++;
      end
      if (out_token_out !== want.tok) begin
        $display("%0t: token mismatch: expected %h, actual %h", $time, want.tok, out_token_out);
        errors++;
      end
      if (out_list_length !== want.len) begin
        $display("%0t: length mismatch: expected %0d, actual %0d", $time, want.len,
                 out_list_length);
        errors++;
      end
      if (out_last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, out_last);
        errors++;
      end
    end
  endtask

  // Monitor both channels at the rising edge and watch for a stuck block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_list_step(in_mode, in_position, in_token);
      if (out_valid && out_ready) check_list_result();
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result-side backpressure in random bursts.
  always @(negedge clk) begin
    if (ready_stall_left > 0) begin
      out_ready = 1'b0;
      ready_stall_left--;
    end else if (idle_enabled && $urandom_range(0, 99) < 15) begin
      out_ready = 1'b0;
      ready_stall_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Drive one request transaction; called and returns at a falling edge.
  task automatic send_request(input mode_t mode, input logic [POS_W-1:0] pos,
                              input logic [TOKEN_WIDTH-1:0] tok);
    int gap;
    if (idle_enabled && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_mode     = mode;
    in_position = pos;
    in_token    = tok;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random request: mostly inserts, with positions biased toward the valid range.
  task automatic send_random_request();
    int pick;
    mode_t mode;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 20) mode = MODE_FIRST;
    else if (pick < 40) mode = MODE_LAST;
    else if (pick < 80) mode = MODE_POS;
    else mode = MODE_DISPLAY;
    pick = $urandom_range(0, 99);
    if (pick < 60) pos = POS_W'($urandom_range(1, held_count + 1));
    else if (pick < 70) pos = '0;
    else pos = POS_W'($urandom_range(0, 255));
    send_request(mode, pos, TOKEN_WIDTH'($urandom_range(0, 65535)));
  endtask

  // Requests against an empty list.
  task automatic test_empty_list();
    send_request(MODE_DISPLAY, 8'd0, 16'hFFFF);
    send_request(MODE_POS, 8'd0, 16'h0001);
    send_request(MODE_POS, 8'd2, 16'h0002);
    send_request(MODE_POS, 8'd255, 16'h0003);
  endtask

  // Each insert mode, the token extremes and both position errors on a short list.
  task automatic test_insert_modes();
    send_request(MODE_FIRST, 8'd255, 16'hFFFF);
    send_request(MODE_LAST, 8'd0, 16'h0000);
    send_request(MODE_POS, 8'd1, 16'h1234);
    send_request(MODE_POS, 8'd4, 16'hA5A5);
    send_request(MODE_POS, 8'd2, 16'h5A5A);
    send_request(MODE_POS, 8'd0, 16'hBEEF);
    send_request(MODE_POS, 8'd7, 16'hCAFE);
    send_request(MODE_DISPLAY, 8'd0, 16'h0000);
  endtask

  // Random traffic until the store is full.
  task automatic test_random_fill();
    while (held_count < DEPTH) send_random_request();
  endtask

  // Refused inserts on a full store, including the position checks made first.
  task automatic test_full_store();
    send_request(MODE_FIRST, 8'd1, 16'h1111);
    send_request(MODE_LAST, 8'd1, 16'h2222);
    send_request(MODE_POS, 8'd1, 16'h3333);
    send_request(MODE_POS, 8'd32, 16'h4444);
    send_request(MODE_POS, 8'd33, 16'h5555);
    send_request(MODE_POS, 8'd0, 16'h6666);
    send_request(MODE_DISPLAY, 8'd128, 16'h7777);
  endtask

  // Random traffic on the full store; the final stretch runs without idling.
  task automatic test_random_full();
    int n;
    for (n = 0; n < 100; n++) begin
      if (n == 60) idle_enabled = 1'b0;
      send_random_request();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_insert_modes();
    test_random_fill();
    test_full_store();
    test_random_full();
    in_valid = 1'b0;

    // Drain the remaining results, then give the block time for stray output.
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/plins_pkg.sv
hw/rtl/positional_list_insert_top.sv
sim/positional_list_insert_top_tb.sv
